// ----- rtl/core/gbb_pkg.sv -----
// ============================================================================
// gbb_pkg
// Shared types and constants of the glyph bitmap blit and blend unit.
// ============================================================================
package gbb_pkg;

    localparam int COLOUR_W   = 24;
    localparam int COORD_W    = 16;
    localparam int SRC_W      = 8;
    localparam int WEIGHT_W   = 4;
    localparam int GW_W       = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FG_COLOUR   = 4'd0,
        REG_FG_ENABLE   = 4'd1,
        REG_BG_COLOUR   = 4'd2,
        REG_BG_ENABLE   = 4'd3,
        REG_MONO_MODE   = 4'd4,
        REG_GLYPH_WIDTH = 4'd5,
        REG_ORIGIN_X    = 4'd6,
        REG_ORIGIN_Y    = 4'd7
    } t_reg_idx;

    localparam logic [COLOUR_W-1:0] RST_FG_COLOUR   = 24'hFFFFFF;
    localparam logic                RST_FG_ENABLE   = 1'b1;
    localparam logic [COLOUR_W-1:0] RST_BG_COLOUR   = 24'h000000;
    localparam logic                RST_BG_ENABLE   = 1'b0;
    localparam logic                RST_MONO_MODE   = 1'b1;
    localparam logic [GW_W-1:0]     RST_GLYPH_WIDTH = 9'd8;
    localparam logic [COORD_W-1:0]  RST_ORIGIN_X    = 16'd0;
    localparam logic [COORD_W-1:0]  RST_ORIGIN_Y    = 16'd0;

    typedef struct packed {
        logic [COLOUR_W-1:0] fg_colour;
        logic                fg_enable;
        logic [COLOUR_W-1:0] bg_colour;
        logic                bg_enable;
        logic                mono_mode;
        logic [GW_W-1:0]     glyph_width;
        logic [COORD_W-1:0]  origin_x;
        logic [COORD_W-1:0]  origin_y;
    } t_cfg;

    // classified pixel between front and back
    typedef struct packed {
        logic                write_enable;
        logic                blend;
        logic [COLOUR_W-1:0] colour;
        logic [WEIGHT_W-1:0] weight;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic                glyph_done;
    } t_job;

    typedef struct packed {
        logic                write_enable;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                glyph_done;
    } t_pix;

endpackage

// ----- rtl/core/gbb_fifo.sv -----
// ============================================================================
// gbb_fifo
// Small register queue with push/full and pop/empty sides.
// ============================================================================
module gbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/gbb_front.sv -----
// ============================================================================
// gbb_front
// Position counters, target coordinates and pixel classification.
// ============================================================================
module gbb_front import gbb_pkg::*; #(
    parameter int MAX_GLYPH_DIM = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_accept,
    input  logic [SRC_W-1:0]    i_src_byte,
    input  logic [COLOUR_W-1:0] i_dest_colour,
    input  logic                i_last_pixel,
    output t_job                o_job
);

    localparam int CNT_W = $clog2(MAX_GLYPH_DIM);
    localparam int DIM_W = $clog2(MAX_GLYPH_DIM + 1);
    localparam int CMP_W = (DIM_W > GW_W) ? DIM_W : GW_W;
    localparam logic [CMP_W-1:0] DIM = CMP_W'(MAX_GLYPH_DIM);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CMP_W-1:0] gw_ext, width_eff, col_inc, row_inc;
    logic [2:0]       bit_idx;
    logic             mono_bit;

    always_comb begin
        gw_ext    = CMP_W'(i_cfg.glyph_width);
        width_eff = (gw_ext == '0 || gw_ext > DIM) ? DIM : gw_ext;
        col_inc   = CMP_W'(r_col) + 1'b1;
        row_inc   = CMP_W'(r_row) + 1'b1;
        n_col     = r_col;
        n_row     = r_row;
        priority if (i_last_pixel) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= width_eff) begin
            n_col = '0;
            n_row = (row_inc >= DIM) ? '0 : CNT_W'(row_inc);
        end else begin
            n_col = CNT_W'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        bit_idx  = 3'd7 - 3'(r_col);
        mono_bit = i_src_byte[bit_idx];

        o_job              = '0;
        o_job.weight       = i_src_byte[SRC_W-1 -: WEIGHT_W];
        o_job.pixel_x      = i_cfg.origin_x + COORD_W'(r_col);
        o_job.pixel_y      = i_cfg.origin_y + COORD_W'(r_row);
        o_job.glyph_done   = i_last_pixel;

        priority if (i_cfg.mono_mode) begin
            if (mono_bit && i_cfg.fg_enable) begin
                o_job.write_enable = 1'b1;
                o_job.colour       = i_cfg.fg_colour;
            end else if (!mono_bit && i_cfg.bg_enable) begin
                o_job.write_enable = 1'b1;
                o_job.colour       = i_cfg.bg_colour;
            end
        end else if (i_src_byte != '0) begin
            if (i_cfg.fg_enable) begin
                o_job.write_enable = 1'b1;
                o_job.blend        = 1'b1;
                o_job.colour       = i_cfg.bg_enable ? i_cfg.bg_colour : i_dest_colour;
            end
        end else if (i_cfg.bg_enable) begin
            o_job.write_enable = 1'b1;
            o_job.colour       = i_cfg.bg_colour;
        end
    end

endmodule

// ----- rtl/core/gbb_back.sv -----
// ============================================================================
// gbb_back
// Per-channel coverage blend of the foreground over the base colour, or pass-through.
// ============================================================================
module gbb_back import gbb_pkg::*; (
    input  logic [COLOUR_W-1:0] i_fg_colour,
    input  t_job                i_job,
    input  logic                i_job_valid,
    input  logic                i_out_full,
    output logic                o_take,
    output t_pix                o_pix
);

    function automatic logic [7:0] blend_ch(
        input logic [7:0]          base,
        input logic [7:0]          fore,
        input logic [WEIGHT_W-1:0] p
    );
        logic [11:0] sum;
        sum = 12'(base * (4'd15 - p)) + 12'(fore * p);
        return sum[11:4];
    endfunction

    logic [COLOUR_W-1:0] mixed;

    assign o_take = i_job_valid && !i_out_full;

    always_comb begin
        mixed = {blend_ch(i_job.colour[23:16], i_fg_colour[23:16], i_job.weight),
                 blend_ch(i_job.colour[15:8],  i_fg_colour[15:8],  i_job.weight),
                 blend_ch(i_job.colour[7:0],   i_fg_colour[7:0],   i_job.weight)};
        o_pix.write_enable = i_job.write_enable;
        o_pix.pixel_x      = i_job.pixel_x;
        o_pix.pixel_y      = i_job.pixel_y;
        o_pix.pixel_colour = i_job.blend ? mixed : i_job.colour;
        o_pix.glyph_done   = i_job.glyph_done;
    end

endmodule

// ----- rtl/core/glyph_bitmap_blit_blend_unit.sv -----
// ============================================================================
// glyph_bitmap_blit_blend_unit
// Expands glyph bitmap pixels into frame buffer writes with optional blend.
// ============================================================================
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     push / full          src_byte, dest_colour, last_pixel
//  result    pop / empty          write_enable, pixel_x, pixel_y, pixel_colour,
//                                 glyph_done
//  config    cfg_we               cfg_index, cfg_data
//
//  one pixel per cycle sustained while pop keeps up; results pass both queues
//  front classifies in the push cycle, two-entry queue, back blends into a
//  two-entry result queue
//  synchronous active-low reset clears counters, queues and config registers
//  either side may stall; up to four transactions are held inside
// ============================================================================
module glyph_bitmap_blit_blend_unit import gbb_pkg::*; #(
    parameter int MAX_GLYPH_DIM = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [SRC_W-1:0]      i_src_byte,
    input  logic [COLOUR_W-1:0]   i_dest_colour,
    input  logic                  i_last_pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_write_enable,
    output logic signed [COORD_W-1:0] o_pixel_x,
    output logic signed [COORD_W-1:0] o_pixel_y,
    output logic [COLOUR_W-1:0]   o_pixel_colour,
    output logic                  o_glyph_done
);

    t_cfg r_cfg;
    t_job front_job, head_job;
    t_pix back_pix, out_pix;
    logic in_accept, job_empty, job_full, back_take, out_full;
    logic [2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_colour   <= RST_FG_COLOUR;
            r_cfg.fg_enable   <= RST_FG_ENABLE;
            r_cfg.bg_colour   <= RST_BG_COLOUR;
            r_cfg.bg_enable   <= RST_BG_ENABLE;
            r_cfg.mono_mode   <= RST_MONO_MODE;
            r_cfg.glyph_width <= RST_GLYPH_WIDTH;
            r_cfg.origin_x    <= RST_ORIGIN_X;
            r_cfg.origin_y    <= RST_ORIGIN_Y;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FG_COLOUR:   r_cfg.fg_colour   <= i_cfg_data[COLOUR_W-1:0];
                REG_FG_ENABLE:   r_cfg.fg_enable   <= i_cfg_data[0];
                REG_BG_COLOUR:   r_cfg.bg_colour   <= i_cfg_data[COLOUR_W-1:0];
                REG_BG_ENABLE:   r_cfg.bg_enable   <= i_cfg_data[0];
                REG_MONO_MODE:   r_cfg.mono_mode   <= i_cfg_data[0];
                REG_GLYPH_WIDTH: r_cfg.glyph_width <= i_cfg_data[GW_W-1:0];
                REG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign full      = job_full;
    assign in_accept = push && !job_full;

    gbb_front #(
        .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_src_byte    (i_src_byte),
        .i_dest_colour (i_dest_colour),
        .i_last_pixel  (i_last_pixel),
        .o_job         (front_job)
    );

    gbb_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (job_full),
        .i_pop   (back_take),
        .o_data  (head_job),
        .o_empty (job_empty)
    );

    gbb_back u_back (
        .i_fg_colour (r_cfg.fg_colour),
        .i_job       (head_job),
        .i_job_valid (!job_empty),
        .i_out_full  (out_full),
        .o_take      (back_take),
        .o_pix       (back_pix)
    );

    gbb_fifo #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_take),
        .i_data  (back_pix),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_pix),
        .o_empty (empty)
    );

    assign o_write_enable = out_pix.write_enable;
    assign o_pixel_x      = out_pix.pixel_x;
    assign o_pixel_y      = out_pix.pixel_y;
    assign o_pixel_colour = out_pix.pixel_colour;
    assign o_glyph_done   = out_pix.glyph_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_accept && !(pop && !empty)) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (!in_accept && pop && !empty) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more transactions held than queue capacity");

    a_empty_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 3'd0) |-> (empty && job_empty))
        else $error("result present with no transaction in flight");

    a_origin_x_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == REG_ORIGIN_X)
        |=> (r_cfg.origin_x == $past(i_cfg_data[COORD_W-1:0])))
        else $error("origin_x write lost");

endmodule

// ----- tb/glyph_blit_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// glyph_blit_checker
// Watches the config port and both queue sides of the glyph blit unit, keeps
// its own copy of the registers and pixel counters, predicts every pixel
// write and compares each popped transaction field by field in order.
// ============================================================================
module glyph_blit_checker import gbb_pkg::*; #(
    parameter int MAX_GLYPH_DIM = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        push,
    input  logic                        full,
    input  logic [SRC_W-1:0]            src_byte,
    input  logic [COLOUR_W-1:0]         dest_colour,
    input  logic                        last_pixel,
    input  logic                        empty,
    input  logic                        pop,
    input  logic                        write_enable,
    input  logic signed [COORD_W-1:0]   pixel_x,
    input  logic signed [COORD_W-1:0]   pixel_y,
    input  logic [COLOUR_W-1:0]         pixel_colour,
    input  logic                        glyph_done,
    output int                          fail_count,
    output int                          pending,
    output int                          pixels_checked,
    output int                          pixels_written
);

    t_cfg       shadow;
    logic [7:0] col_pos;
    logic [7:0] row_pos;
    t_pix       pixel_queue[$];
    int         errors;
    int         checked;
    int         written;

    initial begin
        errors  = 0;
        checked = 0;
        written = 0;
    end

    function automatic logic [7:0] blend_chan(logic [7:0] base, logic [7:0] fore,
                                              logic [WEIGHT_W-1:0] p);
        int mix;
        mix = (int'(base) * (15 - int'(p)) + int'(fore) * int'(p)) / 16;
        return mix[7:0];
    endfunction

    function automatic t_pix predict_pixel(t_cfg c, logic [7:0] col, logic [7:0] row,
                                           logic [SRC_W-1:0] src, logic [COLOUR_W-1:0] dest,
                                           logic last);
        t_pix                px;
        logic                bit_on;
        logic [COLOUR_W-1:0] base;
        logic [WEIGHT_W-1:0] p;
        px = '0;
        if (c.mono_mode) begin
            bit_on = src[3'd7 - col[2:0]];
            if (bit_on && c.fg_enable) begin
                px.write_enable = 1'b1;
                px.pixel_colour = c.fg_colour;
            end
            if (!bit_on && c.bg_enable) begin
                px.write_enable = 1'b1;
                px.pixel_colour = c.bg_colour;
            end
        end else if (src != '0) begin
            if (c.fg_enable) begin
                base = c.bg_enable ? c.bg_colour : dest;
                p    = src[7:4];
                px.write_enable = 1'b1;
                px.pixel_colour = {blend_chan(base[23:16], c.fg_colour[23:16], p),
                                   blend_chan(base[15:8],  c.fg_colour[15:8],  p),
                                   blend_chan(base[7:0],   c.fg_colour[7:0],   p)};
            end
        end else if (c.bg_enable) begin
            px.write_enable = 1'b1;
            px.pixel_colour = c.bg_colour;
        end
        px.pixel_x    = c.origin_x + {8'h00, col};
        px.pixel_y    = c.origin_y + {8'h00, row};
        px.glyph_done = last;
        return px;
    endfunction

    task automatic check_field(string field, logic [23:0] exp_val, logic [23:0] act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("%0t %s expected %0h got %0h", $time, field, exp_val, act_val);
        end
    endtask

    always @(posedge clk) begin
        t_pix want;
        int   span;
        if (!rst_n) begin
            shadow.fg_colour   = RST_FG_COLOUR;
            shadow.fg_enable   = RST_FG_ENABLE;
            shadow.bg_colour   = RST_BG_COLOUR;
            shadow.bg_enable   = RST_BG_ENABLE;
            shadow.mono_mode   = RST_MONO_MODE;
            shadow.glyph_width = RST_GLYPH_WIDTH;
            shadow.origin_x    = RST_ORIGIN_X;
            shadow.origin_y    = RST_ORIGIN_Y;
            col_pos = '0;
            row_pos = '0;
            pixel_queue.delete();
        end else begin
            if (pop && !empty) begin
                if (pixel_queue.size() == 0) begin
                    errors++;
                    $display("%0t unexpected transaction: expected none got x=%0h y=%0h",
                             $time, pixel_x, pixel_y);
                end else begin
                    want = pixel_queue.pop_front();
                    check_field("write_enable", want.write_enable, write_enable);
                    check_field("pixel_x", want.pixel_x, $unsigned(pixel_x));
                    check_field("pixel_y", want.pixel_y, $unsigned(pixel_y));
                    check_field("pixel_colour", want.pixel_colour, pixel_colour);
                    check_field("glyph_done", want.glyph_done, glyph_done);
                    checked++;
                    if (want.write_enable) written++;
                end
            end
            if (push && !full) begin
                pixel_queue.push_back(predict_pixel(shadow, col_pos, row_pos, src_byte,
                                                    dest_colour, last_pixel));
                span = (shadow.glyph_width == 0 || shadow.glyph_width > MAX_GLYPH_DIM) ?
                       MAX_GLYPH_DIM : int'(shadow.glyph_width);
                if (last_pixel) begin
                    col_pos = '0;
                    row_pos = '0;
                end else if (int'(col_pos) + 1 >= span) begin
                    col_pos = '0;
                    row_pos = (int'(row_pos) + 1 >= MAX_GLYPH_DIM) ? 8'd0 : row_pos + 8'd1;
                end else begin
                    col_pos = col_pos + 8'd1;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_FG_COLOUR:   shadow.fg_colour   = cfg_data[COLOUR_W-1:0];
                    REG_FG_ENABLE:   shadow.fg_enable   = cfg_data[0];
                    REG_BG_COLOUR:   shadow.bg_colour   = cfg_data[COLOUR_W-1:0];
                    REG_BG_ENABLE:   shadow.bg_enable   = cfg_data[0];
                    REG_MONO_MODE:   shadow.mono_mode   = cfg_data[0];
                    REG_GLYPH_WIDTH: shadow.glyph_width = cfg_data[GW_W-1:0];
                    REG_ORIGIN_X:    shadow.origin_x    = cfg_data[COORD_W-1:0];
                    REG_ORIGIN_Y:    shadow.origin_y    = cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count     <= errors;
        pending        <= pixel_queue.size();
        pixels_checked <= checked;
        pixels_written <= written;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives glyph pixel streams through the blit unit under changing register
// settings: directed corner pixels first, then long strips, then random glyphs
// and broken glyphs, with random push gaps and pop stalls. The checker beside
// the unit predicts and compares; this module gives the verdict.
// ============================================================================
module testbench import gbb_pkg::*; ();

    localparam int MAX_GLYPH_DIM  = 256;
    localparam int ITEM_TARGET    = 1450;
    localparam int QUIET_TAIL     = 150;
    localparam int GLYPH_ITEM_CAP = 48;
    localparam int DRAIN_CYCLES   = 8;
    localparam int FIRST_SPARE_REG = int'(REG_ORIGIN_Y) + 1;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      push;
    logic                      full;
    logic [SRC_W-1:0]          src_byte;
    logic [COLOUR_W-1:0]       dest_colour;
    logic                      last_pixel;
    logic                      empty;
    logic                      pop;
    logic                      write_enable;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOUR_W-1:0]       pixel_colour;
    logic                      glyph_done;
    int                        fail_count;
    int                        pending;
    int                        pixels_checked;
    int                        pixels_written;

    logic idle_on = 1'b1;
    int   items_sent = 0;
    int   phases = 0;
    t_cfg cfg;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    glyph_bitmap_blit_blend_unit #(.MAX_GLYPH_DIM(MAX_GLYPH_DIM)) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .push           (push),
        .full           (full),
        .i_src_byte     (src_byte),
        .i_dest_colour  (dest_colour),
        .i_last_pixel   (last_pixel),
        .empty          (empty),
        .pop            (pop),
        .o_write_enable (write_enable),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_pixel_colour (pixel_colour),
        .o_glyph_done   (glyph_done)
    );

    glyph_blit_checker #(.MAX_GLYPH_DIM(MAX_GLYPH_DIM)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .src_byte       (src_byte),
        .dest_colour    (dest_colour),
        .last_pixel     (last_pixel),
        .empty          (empty),
        .pop            (pop),
        .write_enable   (write_enable),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_colour   (pixel_colour),
        .glyph_done     (glyph_done),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked),
        .pixels_written (pixels_written)
    );

    function automatic logic [COLOUR_W-1:0] pick_colour();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return COLOUR_W'($urandom());
    endfunction

    function automatic logic [SRC_W-1:0] pick_src(logic mono);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (mono ? 8 : 20)) return '0;
        if (roll < (mono ? 16 : 30)) return '1;
        if (!mono && roll < 45) return SRC_W'($urandom_range(1, 15));
        return SRC_W'($urandom());
    endfunction

    function automatic logic [COORD_W-1:0] pick_origin();
        case ($urandom_range(0, 7))
            0: return COORD_W'($urandom_range(16'h7FF0, 16'h800F));
            1: return COORD_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        int   roll;
        c.fg_colour = pick_colour();
        c.fg_enable = 1'($urandom());
        c.bg_colour = pick_colour();
        c.bg_enable = 1'($urandom());
        c.mono_mode = 1'($urandom());
        roll = $urandom_range(0, 99);
        if (roll < 70)      c.glyph_width = GW_W'($urandom_range(1, 12));
        else if (roll < 85) c.glyph_width = GW_W'($urandom_range(13, 40));
        else case ($urandom_range(0, 4))
            0: c.glyph_width = GW_W'(0);
            1: c.glyph_width = GW_W'(1);
            2: c.glyph_width = GW_W'(MAX_GLYPH_DIM - 1);
            3: c.glyph_width = GW_W'(MAX_GLYPH_DIM);
            default: c.glyph_width = '1;
        endcase
        c.origin_x = pick_origin();
        c.origin_y = pick_origin();
        return c;
    endfunction

    task automatic write_raw(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // all registers, junk in the unused upper data bits
    task automatic load_config(t_cfg c);
        if ($urandom_range(0, 2) == 0)
            write_raw(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, FIRST_SPARE_REG)),
                      CFG_DATA_W'($urandom()));
        write_raw(REG_FG_COLOUR,   c.fg_colour);
        write_raw(REG_FG_ENABLE,   {23'($urandom()), c.fg_enable});
        write_raw(REG_BG_COLOUR,   c.bg_colour);
        write_raw(REG_BG_ENABLE,   {23'($urandom()), c.bg_enable});
        write_raw(REG_MONO_MODE,   {23'($urandom()), c.mono_mode});
        write_raw(REG_GLYPH_WIDTH, {15'($urandom()), c.glyph_width});
        write_raw(REG_ORIGIN_X,    {8'($urandom()), c.origin_x});
        write_raw(REG_ORIGIN_Y,    {8'($urandom()), c.origin_y});
        cfg_we <= 1'b0;
        phases++;
    endtask

    task automatic send_pixel(logic [SRC_W-1:0] src, logic [COLOUR_W-1:0] dest, logic last);
        if (idle_on && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        push        <= 1'b1;
        src_byte    <= src;
        dest_colour <= dest;
        last_pixel  <= last;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // wait for every pending transaction to drain before touching registers
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_glyph(t_cfg c);
        int span;
        int rows;
        int total;
        int stop_at;
        int kind;
        span  = (c.glyph_width == 0 || c.glyph_width > MAX_GLYPH_DIM) ?
                MAX_GLYPH_DIM : int'(c.glyph_width);
        rows  = $urandom_range(1, 4);
        total = (span * rows > GLYPH_ITEM_CAP) ? GLYPH_ITEM_CAP : span * rows;
        kind  = $urandom_range(0, 99);
        stop_at = total - 1;
        if (kind >= 88)      stop_at = -1;
        else if (kind >= 74) stop_at = $urandom_range(0, total - 1);
        for (int i = 0; i < total; i++) begin
            send_pixel(pick_src(c.mono_mode), pick_colour(),
                       (i == stop_at) || ($urandom_range(0, 99) < 2));
            if (i == stop_at) break;
        end
    endtask

    task automatic send_strip(logic [GW_W-1:0] width);
        cfg = random_config();
        cfg.glyph_width = width;
        load_config(cfg);
        repeat (MAX_GLYPH_DIM + 2) send_pixel(pick_src(cfg.mono_mode), pick_colour(), 1'b0);
        send_pixel(pick_src(cfg.mono_mode), pick_colour(), 1'b1);
        settle();
    endtask

    initial begin
        #1_000_000;
        $display("glyph_bitmap_blit_blend_unit: mismatch");
        $finish;
    end

    initial begin
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (idle_on && $urandom_range(0, 99) < 20) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end else begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        push        <= 1'b0;
        src_byte    <= '0;
        dest_colour <= '0;
        last_pixel  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: mono, fg only, width 8
        for (int i = 0; i < 8; i++) send_pixel(8'hA5, 24'h0, i == 7);
        settle();

        // gray over bg, zero and low coverage, x wraps past max positive
        cfg = '{fg_colour: 24'h000000, fg_enable: 1'b1, bg_colour: 24'hFFFFFF,
                bg_enable: 1'b1, mono_mode: 1'b0, glyph_width: 9'd4,
                origin_x: 16'h7FFE, origin_y: 16'h8000};
        load_config(cfg);
        send_pixel(8'h00, 24'h123456, 1'b0);
        send_pixel(8'h0F, 24'h123456, 1'b0);
        send_pixel(8'h10, 24'h123456, 1'b0);
        send_pixel(8'hFF, 24'h123456, 1'b0);
        send_pixel(8'h80, 24'hFFFFFF, 1'b0);
        send_pixel(8'h01, 24'h000000, 1'b0);
        send_pixel(8'hFF, 24'hABCDEF, 1'b1);
        settle();

        // gray over destination, no background
        cfg = '{fg_colour: 24'hFFFFFF, fg_enable: 1'b1, bg_colour: 24'h000000,
                bg_enable: 1'b0, mono_mode: 1'b0, glyph_width: 9'd1,
                origin_x: 16'hFFFF, origin_y: 16'h7FFF};
        load_config(cfg);
        send_pixel(8'h80, 24'h000000, 1'b0);
        send_pixel(8'hFF, 24'hFFFFFF, 1'b0);
        send_pixel(8'h00, 24'h00FF00, 1'b0);
        send_pixel(8'h7F, 24'hFF00FF, 1'b1);
        settle();

        // both transparent in mono, width zero
        cfg.fg_enable   = 1'b0;
        cfg.mono_mode   = 1'b1;
        cfg.glyph_width = 9'd0;
        load_config(cfg);
        send_pixel(8'hFF, 24'h0, 1'b0);
        send_pixel(8'h00, 24'h0, 1'b0);
        settle();

        // gray with foreground off, background on
        cfg.bg_enable = 1'b1;
        cfg.mono_mode = 1'b0;
        load_config(cfg);
        send_pixel(8'h40, 24'h55AA55, 1'b0);
        send_pixel(8'h00, 24'h55AA55, 1'b1);
        settle();

        // row counter overflow, then an oversized or zero width
        send_strip(9'd1);
        send_strip($urandom_range(0, 1) ? GW_W'(0) : GW_W'($urandom_range(257, 511)));

        while (items_sent < ITEM_TARGET) begin
            cfg = random_config();
            idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            load_config(cfg);
            repeat ($urandom_range(1, 4)) begin
                if (items_sent >= ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
                send_glyph(cfg);
            end
            settle();
        end

        settle();
        $display("covered %0d pixels under %0d register settings, %0d of them written",
                 pixels_checked, phases, pixels_written);
        if (fail_count == 0 && pending == 0) begin
            $display("glyph_bitmap_blit_blend_unit: match");
        end else begin
            $display("glyph_bitmap_blit_blend_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gbb_pkg.sv
rtl/core/gbb_fifo.sv
rtl/core/gbb_front.sv
rtl/core/gbb_back.sv
rtl/core/glyph_bitmap_blit_blend_unit.sv
tb/glyph_blit_checker.sv
tb/testbench.sv
